// ===== rtl/ial_pkg.sv =====
package ial_pkg;

  // list capacity and derived widths
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 7;
  localparam int DW    = 64;

  // command codes
  localparam logic [3:0] CMD_APPEND     = 4'd0;
  localparam logic [3:0] CMD_POP_BACK   = 4'd1;
  localparam logic [3:0] CMD_INSERT     = 4'd2;
  localparam logic [3:0] CMD_ERASE      = 4'd3;
  localparam logic [3:0] CMD_READ_AT    = 4'd4;
  localparam logic [3:0] CMD_READ_FRONT = 4'd5;
  localparam logic [3:0] CMD_READ_BACK  = 4'd6;
  localparam logic [3:0] CMD_CLEAR      = 4'd7;
  localparam logic [3:0] CMD_RESIZE     = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // store access issued by the sequencer
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  // one finished result word
  typedef struct packed {
    logic [DW-1:0] read_value;
    logic [1:0]    status;
    logic [CW-1:0] length_now;
    logic          is_empty;
  } result_t;

endpackage

// ===== rtl/ial_ram.sv =====
module ial_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ial_seq.sv =====
module ial_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              cmd,
  input  logic [ial_pkg::CW-1:0]  position,
  input  logic [ial_pkg::DW-1:0]  value,
  output ial_pkg::mem_req_t       mem_req,
  input  logic [ial_pkg::DW-1:0]  rdata,
  output logic                    res_valid,
  input  logic                    res_take,
  output ial_pkg::result_t        res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_UPWR = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [ial_pkg::CW-1:0] ONE  = ial_pkg::CW'(1);
  localparam logic [ial_pkg::CW-1:0] TWO  = ial_pkg::CW'(2);
  localparam logic [ial_pkg::CW-1:0] FULL = ial_pkg::CW'(ial_pkg::DEPTH);

  logic [2:0]               state, state_next;
  logic [ial_pkg::CW-1:0]   count, count_next;
  logic [ial_pkg::CW-1:0]   ptr, ptr_next;
  logic [ial_pkg::CW-1:0]   pos_r, pos_next;
  logic [ial_pkg::DW-1:0]   val_r, val_next;
  logic [ial_pkg::DW-1:0]   rdval, rdval_next;
  logic [1:0]               status, status_next;

  logic [ial_pkg::CW-1:0]   cnt_m1, pos_p1, ptr_m1, ptr_m2, ptr_p1, ptr_p2;

  assign cnt_m1 = count - ONE;
  assign pos_p1 = position + ONE;
  assign ptr_m1 = ptr - ONE;
  assign ptr_m2 = ptr - TWO;
  assign ptr_p1 = ptr + ONE;
  assign ptr_p2 = ptr + TWO;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    pos_r  <= pos_next;
    val_r  <= val_next;
    rdval  <= rdval_next;
    status <= status_next;
  end

  // command sequencing
  always_comb begin
    state_next    = state;
    count_next    = count;
    ptr_next      = ptr;
    pos_next      = pos_r;
    val_next      = val_r;
    rdval_next    = rdval;
    status_next   = status;
    mem_req.we    = 1'b0;
    mem_req.waddr = ptr[ial_pkg::AW-1:0];
    mem_req.wdata = rdata;
    mem_req.raddr = '0;
    res_valid     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          pos_next    = position;
          val_next    = value;
          status_next = ial_pkg::ST_OK;
          rdval_next  = '0;
          state_next  = S_FIN;
          case (cmd)
            ial_pkg::CMD_APPEND: begin
              if (count == FULL) begin
                status_next = ial_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count[ial_pkg::AW-1:0];
                mem_req.wdata = value;
                count_next    = count + ONE;
              end
            end
            ial_pkg::CMD_POP_BACK: begin
              if (count == '0) begin
                status_next = ial_pkg::ST_RANGE;
              end else begin
                count_next = cnt_m1;
              end
            end
            ial_pkg::CMD_INSERT: begin
              if (position > count) begin
                status_next = ial_pkg::ST_RANGE;
              end else if (count == FULL) begin
                status_next = ial_pkg::ST_FULL;
              end else if (position == count) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = position[ial_pkg::AW-1:0];
                mem_req.wdata = value;
                count_next    = count + ONE;
              end else begin
                // move entries up from the tail
                mem_req.raddr = cnt_m1[ial_pkg::AW-1:0];
                ptr_next      = count;
                state_next    = S_UP;
              end
            end
            ial_pkg::CMD_ERASE: begin
              if (position >= count) begin
                status_next = ial_pkg::ST_RANGE;
              end else if (position == cnt_m1) begin
                count_next = cnt_m1;
              end else begin
                // move entries down from the erased slot
                mem_req.raddr = pos_p1[ial_pkg::AW-1:0];
                ptr_next      = position;
                state_next    = S_DN;
              end
            end
            ial_pkg::CMD_READ_AT: begin
              if (position >= count) begin
                status_next = ial_pkg::ST_RANGE;
              end else begin
                mem_req.raddr = position[ial_pkg::AW-1:0];
                state_next    = S_RD;
              end
            end
            ial_pkg::CMD_READ_FRONT: begin
              if (count == '0) begin
                status_next = ial_pkg::ST_RANGE;
              end else begin
                mem_req.raddr = '0;
                state_next    = S_RD;
              end
            end
            ial_pkg::CMD_READ_BACK: begin
              if (count == '0) begin
                status_next = ial_pkg::ST_RANGE;
              end else begin
                mem_req.raddr = cnt_m1[ial_pkg::AW-1:0];
                state_next    = S_RD;
              end
            end
            ial_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            ial_pkg::CMD_RESIZE: begin
              if (position > FULL) begin
                status_next = ial_pkg::ST_FULL;
              end else if (position <= count) begin
                count_next = position;
              end else begin
                ptr_next   = count;
                state_next = S_FILL;
              end
            end
            default: begin
              status_next = ial_pkg::ST_RANGE;
            end
          endcase
        end
      end
      S_UP: begin
        // store[ptr] takes store[ptr-1], read one slot lower
        mem_req.we = 1'b1;
        if (ptr_m1 > pos_r) begin
          mem_req.raddr = ptr_m2[ial_pkg::AW-1:0];
          ptr_next      = ptr_m1;
        end else begin
          state_next = S_UPWR;
        end
      end
      S_UPWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r[ial_pkg::AW-1:0];
        mem_req.wdata = val_r;
        count_next    = count + ONE;
        state_next    = S_FIN;
      end
      S_DN: begin
        // store[ptr] takes store[ptr+1], read one slot higher
        mem_req.we = 1'b1;
        if (ptr_p2 < count) begin
          mem_req.raddr = ptr_p2[ial_pkg::AW-1:0];
          ptr_next      = ptr_p1;
        end else begin
          count_next = cnt_m1;
          state_next = S_FIN;
        end
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = val_r;
        if (ptr_p1 == pos_r) begin
          count_next = pos_r;
          state_next = S_FIN;
        end else begin
          ptr_next = ptr_p1;
        end
      end
      S_RD: begin
        rdval_next = rdata;
        state_next = S_FIN;
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall       = (state != S_IDLE);
  assign res.read_value = rdval;
  assign res.status     = status;
  assign res.length_now = count;
  assign res.is_empty   = (count == '0);

endmodule

// ===== rtl/indexed_array_list_core.sv =====
// Ordered list of up to 64 words of 64 bits, driven one command word at a time.
// Input channel: in_valid / in_stall with cmd, position and value. Output
// channel: out_valid / out_stall with read_value, status, length_now and
// is_empty; every command gives exactly one result word.
// The list lives in a single 64x64 RAM with one write and one registered read
// port. One command is worked on at a time; in_stall is high while it runs.
// Push, pop, clear, a shrinking resize, insert or erase at the tail and all
// rejected commands go straight to the result; reads first wait for the
// registered RAM read; insert moves entries up and then writes the new value,
// erase moves entries down and a growing resize fills the new slots; the
// store moves or fills one entry per cycle through its single write port.
// With out_stall low the next command is taken in the cycle its predecessor's
// result shows on out_valid.
// The result sits in an output register, so the next command is accepted while
// a result still waits; if out_stall holds, the next result waits inside the
// sequencer and no further command is taken.
// Reset (rst, synchronous) empties the list and drops any pending result; RAM
// contents are not cleared since no entry is read before it is written.
module indexed_array_list_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              cmd,
  input  logic [6:0]              position,
  input  logic [63:0]             value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [63:0]             read_value,
  output logic [1:0]              status,
  output logic [6:0]              length_now,
  output logic                    is_empty
);

  ial_pkg::mem_req_t             mem_req;
  logic [ial_pkg::DW-1:0]        rdata;
  logic                          res_valid;
  logic                          res_take;
  ial_pkg::result_t              res;
  ial_pkg::result_t              out_word;

  // element store
  ial_ram #(
    .WIDTH (ial_pkg::DW),
    .DEPTH (ial_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // command sequencer
  ial_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .position  (position),
    .value     (value),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register takes a word when empty or being drained
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_word <= res;
    end
  end

  assign read_value = out_word.read_value;
  assign status     = out_word.status;
  assign length_now = out_word.length_now;
  assign is_empty   = out_word.is_empty;

endmodule

// ===== tb/sv/ial_list_checker.sv =====
module ial_list_checker
  import ial_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [3:0]    cmd,
  input  logic [6:0]    position,
  input  logic [63:0]   value,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [63:0]   read_value,
  input  logic [1:0]    status,
  input  logic [6:0]    length_now,
  input  logic          is_empty,
  output int            mismatch_count,
  output int            results_owed
);

  // mirror of the list contents and length
  logic [DW-1:0] mirror_words [DEPTH];
  int            mirror_len;

  // results still owed by the block, oldest first
  result_t owed_results [$];

  // apply one command word to the mirror and work out its result
  task automatic run_list_cmd(input logic [3:0] c, input logic [6:0] p_in,
                              input logic [DW-1:0] v, output result_t res);
    int n;
    int p;
    int i;
    res = '0;
    res.status = ST_OK;
    n = mirror_len;
    p = p_in;
    case (c)
      CMD_APPEND: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          mirror_words[n] = v;
          n++;
        end
      end
      CMD_POP_BACK: begin
        if (n == 0) res.status = ST_RANGE;
        else n--;
      end
      CMD_INSERT: begin
        // position check comes ahead of the full check
        if (p > n) begin
          res.status = ST_RANGE;
        end else if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = n; i > p; i--) mirror_words[i] = mirror_words[i-1];
          mirror_words[p] = v;
          n++;
        end
      end
      CMD_ERASE: begin
        if (p >= n) begin
          res.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < n; i++) mirror_words[i] = mirror_words[i+1];
          n--;
        end
      end
      CMD_READ_AT: begin
        if (p >= n) res.status = ST_RANGE;
        else res.read_value = mirror_words[p];
      end
      CMD_READ_FRONT: begin
        if (n == 0) res.status = ST_RANGE;
        else res.read_value = mirror_words[0];
      end
      CMD_READ_BACK: begin
        if (n == 0) res.status = ST_RANGE;
        else res.read_value = mirror_words[n-1];
      end
      CMD_CLEAR: begin
        n = 0;
      end
      CMD_RESIZE: begin
        // growing fills new slots, shrinking only drops the tail
        if (p > DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = n; i < p; i++) mirror_words[i] = v;
          n = p;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    mirror_len = n;
    res.length_now = CW'(n);
    res.is_empty = (n == 0);
  endtask

  // watch both channels, compare results first, then predict the new word
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      mirror_len = 0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {read_value, status, length_now, is_empty};
        if (owed_results.size() == 0) begin
          $display("%0t: result word with none expected: value %h status %0d",
                   $time, got.read_value, got.status,
                   " length %0d empty %0b", got.length_now, got.is_empty);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h got %h",
                     $time, want.read_value, got.read_value);
            mismatch_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.length_now !== want.length_now) begin
            $display("%0t: length_now expected %0d got %0d",
                     $time, want.length_now, got.length_now);
            mismatch_count++;
          end
          if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0b got %0b", $time, want.is_empty, got.is_empty);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        run_list_cmd(cmd, position, value, want);
        owed_results = {owed_results, want};
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== tb/sv/indexed_array_list_core_test.sv =====
module indexed_array_list_core_test;
  import ial_pkg::*;

  localparam int N_RANDOM       = 1525;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;

  // codes the block rejects
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        out_stall = 1'b0;
  logic [3:0]  cmd       = '0;
  logic [6:0]  position  = '0;
  logic [63:0] value     = '0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] read_value;
  logic [1:0]  status;
  logic [6:0]  length_now;
  logic        is_empty;

  int mismatch_count;
  int results_owed;
  int stuck_cycles = 0;
  int list_len = 0;
  bit sender_quiet = 1'b0;

  always #1 clk = ~clk;

  indexed_array_list_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .status(status),
    .length_now(length_now), .is_empty(is_empty)
  );

  ial_list_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .status(status),
    .length_now(length_now), .is_empty(is_empty),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  // list length as the stimulus sees it, used to aim positions
  function automatic int len_after(logic [3:0] c, logic [6:0] p, int n);
    case (c)
      CMD_APPEND:    return (n < DEPTH) ? n + 1 : n;
      CMD_POP_BACK:  return (n > 0) ? n - 1 : n;
      CMD_INSERT:    return (p <= n && n < DEPTH) ? n + 1 : n;
      CMD_ERASE:     return (p < n) ? n - 1 : n;
      CMD_CLEAR:     return 0;
      CMD_RESIZE:    return (p <= DEPTH) ? int'(p) : n;
      default:       return n;
    endcase
  endfunction

  // random element, with the extremes mixed in
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one command word and hold it until accepted
  task automatic send_word(input logic [3:0] c, input logic [6:0] p, input logic [63:0] v);
    int gap;
    gap = 0;
    if (!sender_quiet && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    list_len = len_after(c, p, list_len);
  endtask

  // receiver: random stalls, one long hold-off, and a quiet stretch
  initial begin
    int cyc;
    cyc = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 1500 && cyc < 1800) out_stall <= 1'b1;
      else if (cyc >= 5000 && cyc < 12000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 7);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("indexed_array_list_core_test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int          item_no;
    int          pick;
    int          t;
    bit          shrinking;
    logic [3:0]  c;
    logic [6:0]  p;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_word(CMD_READ_FRONT, 7'd0, '0);
    send_word(CMD_POP_BACK, 7'd0, '0);
    send_word(CMD_READ_BACK, 7'd0, '0);
    send_word(CMD_READ_AT, 7'd0, '0);
    send_word(CMD_ERASE, 7'd0, '0);
    send_word(CMD_INSERT, 7'd1, '1);
    // a few entries, reads in and out of range
    send_word(CMD_INSERT, 7'd0, '1);
    send_word(CMD_APPEND, 7'd0, '0);
    send_word(CMD_APPEND, 7'd0, 64'h8000_0000_0000_0001);
    send_word(CMD_READ_AT, 7'd3, '0);
    send_word(CMD_READ_AT, 7'd0, '0);
    send_word(CMD_ERASE, 7'd1, '0);
    send_word(CMD_READ_BACK, 7'd0, '0);
    send_word(CMD_UNUSED_HI, 7'h7f, '1);
    send_word(CMD_UNUSED_LO, 7'd0, '0);
    // fill to capacity, then the full and oversized cases
    send_word(CMD_RESIZE, 7'd64, 64'h5555_aaaa_5555_aaaa);
    send_word(CMD_APPEND, 7'd0, '1);
    send_word(CMD_INSERT, 7'd10, '1);
    send_word(CMD_INSERT, 7'd65, '1);
    send_word(CMD_RESIZE, 7'd65, '1);
    send_word(CMD_RESIZE, 7'h7f, '1);
    send_word(CMD_READ_AT, 7'd63, '0);
    // longest shifts, then shrink and clear
    send_word(CMD_ERASE, 7'd0, '0);
    send_word(CMD_INSERT, 7'd0, 64'hdead_beef_0123_4567);
    send_word(CMD_READ_FRONT, 7'd0, '0);
    send_word(CMD_RESIZE, 7'd2, '0);
    send_word(CMD_CLEAR, 7'd0, '0);
    send_word(CMD_RESIZE, 7'd0, '1);

    // random commands, alternating phases of growth and shrinkage
    for (item_no = 0; item_no < N_RANDOM; item_no++) begin
      shrinking    = ((item_no / 90) % 2) == 1;
      sender_quiet = (item_no >= 400 && item_no < 700);
      pick = $urandom_range(0, 99);
      if (pick < 20)      c = shrinking ? CMD_POP_BACK : CMD_APPEND;
      else if (pick < 30) c = CMD_POP_BACK;
      else if (pick < 45) c = shrinking ? CMD_ERASE : CMD_INSERT;
      else if (pick < 57) c = CMD_ERASE;
      else if (pick < 71) c = CMD_READ_AT;
      else if (pick < 77) c = CMD_READ_FRONT;
      else if (pick < 83) c = CMD_READ_BACK;
      else if (pick < 85) c = CMD_CLEAR;
      else if (pick < 95) c = CMD_RESIZE;
      else                c = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));

      // mostly legal positions, some anywhere in the field
      case (c)
        CMD_INSERT: p = 7'($urandom_range(0, list_len));
        CMD_ERASE, CMD_READ_AT: p = (list_len > 0) ? 7'($urandom_range(0, list_len - 1)) : '0;
        CMD_RESIZE: begin
          case ($urandom_range(0, 19))
            0:       t = DEPTH;
            1:       t = 0;
            2:       t = $urandom_range(DEPTH + 1, 127);
            default: begin
              t = list_len + $urandom_range(0, 8) - 4;
              if (t < 0) t = 0;
              if (t > DEPTH) t = DEPTH;
            end
          endcase
          p = 7'(t);
        end
        default: p = 7'($urandom_range(0, 127));
      endcase
      if ($urandom_range(0, 9) == 0) p = 7'($urandom_range(0, 127));
      send_word(c, p, rand_word());
    end
    sender_quiet = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("indexed_array_list_core_test passed");
    end else begin
      $display("indexed_array_list_core_test failed");
    end
    $finish;
  end

endmodule
